FILE: hdl/fcdb_pkg.sv
// Package for the float to centi-dB quantizer: word types, fixed-point
// constants and the elaboration-time scale factor. No dependencies.
`timescale 1ns / 1ps

package fcdb_pkg;

    // input and output words
    typedef struct packed {
        logic [31:0] power_bits;
        logic [31:0] peak_bits;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] power_cdb;
        logic signed [15:0] peak_cdb;
    } out_word_t;

    // classification of an operand
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_NORMAL  = 2'd0;
    localparam kind_t KIND_SILENCE = 2'd1;
    localparam kind_t KIND_SAT     = 2'd2;

    localparam int NSQ      = 56;     // squaring steps for the mantissa log2
    localparam int FRAC_W   = 56;
    localparam int MAG_W    = 63;
    localparam int PROD_W   = 127;    // |log2| * K reaches past 2^126 for the peak lane
    localparam logic [15:0] POS_SAT    = 16'sd32767;
    localparam logic [15:0] NEG_LIMIT  = 16'd12000;

    // per-stage side information
    typedef struct packed {
        kind_t             kind;
        logic signed [8:0] expo;
    } meta_t;

    // log2 fraction by repeated squaring, Q62 in; elaboration only
    function automatic logic [63:0] log2_frac_c(input logic [63:0] y_in, input int n);
        logic [63:0]  y;
        logic [63:0]  f;
        logic [127:0] p;
        y = y_in;
        f = '0;
        for (int i = 0; i < n; i++)
        begin
            p = {64'd0, y} * {64'd0, y};
            y = p[125:62];
            f = {f[62:0], y[63]};
            if (y[63])
                y = y >> 1;
        end
        return f;
    endfunction

    // K = scale / log2(10) in Q54, truncated; elaboration only
    function automatic logic [63:0] scale_k(input logic [63:0] scale);
        logic [63:0]  lg10;
        logic [127:0] num;
        logic [64:0]  r;
        logic [63:0]  q;
        lg10 = (64'd3 << 60) + log2_frac_c(64'd5 << 60, 60);
        num  = {scale << 50, 64'd0};
        r = '0;
        q = '0;
        for (int i = 127; i >= 0; i--)
        begin
            r = {r[63:0], num[i]};
            q = {q[62:0], 1'b0};
            if (r >= {1'b0, lg10})
            begin
                r = r - {1'b0, lg10};
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

endpackage

FILE: hdl/fcdb_level.sv
// One level converter lane: float decode, pipelined log2 by squaring,
// scaling multiply and rounding. Depends on fcdb_pkg.
`timescale 1ns / 1ps

module fcdb_level #(
    parameter logic [63:0] SCALE   = 64'd1000,
    parameter logic [15:0] SILENCE = 16'h8000
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [31:0]        bits,
    output logic               out_valid,
    output logic signed [15:0] cdb
);
    import fcdb_pkg::*;

    localparam logic [63:0] K = scale_k(SCALE);

    // squaring pipeline storage
    logic [63:0]     y_reg    [0:NSQ];
    logic [FRAC_W-1:0] f_reg  [0:NSQ];
    meta_t           m_reg    [0:NSQ];
    logic            v_reg    [0:NSQ];
    logic [63:0]     ll_reg   [0:NSQ-1];
    logic [63:0]     lh_reg   [0:NSQ-1];
    logic [63:0]     hh_reg   [0:NSQ-1];
    logic [FRAC_W-1:0] fa_reg [0:NSQ-1];
    meta_t           ma_reg   [0:NSQ-1];
    logic            va_reg   [0:NSQ-1];

    // decode stage
    logic [7:0]  ex;
    logic [22:0] man;
    kind_t       kind_next;
    assign ex  = bits[30:23];
    assign man = bits[22:0];

    always_comb
    begin
        if (bits[31] || ex == 8'd0)
            kind_next = KIND_SILENCE;
        else if (ex == 8'hFF)
            kind_next = (man != 23'd0) ? KIND_SILENCE : KIND_SAT;
        else
            kind_next = KIND_NORMAL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        y_reg[0]     <= {1'b0, 1'b1, man, 39'd0};
        f_reg[0]     <= '0;
        m_reg[0].kind <= kind_next;
        m_reg[0].expo <= $signed({1'b0, ex}) - 9'sd127;
    end

    // each squaring step: partial products, then sum and renormalise
    for (genvar k = 0; k < NSQ; k++)
    begin : g_sq
        logic [127:0] prod;
        logic [63:0]  ys;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                va_reg[k]  <= 1'b0;
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                va_reg[k]  <= v_reg[k];
                v_reg[k+1] <= va_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            ll_reg[k] <= y_reg[k][31:0] * y_reg[k][31:0];
            lh_reg[k] <= y_reg[k][31:0] * y_reg[k][63:32];
            hh_reg[k] <= y_reg[k][63:32] * y_reg[k][63:32];
            fa_reg[k] <= f_reg[k];
            ma_reg[k] <= m_reg[k];
        end

        assign prod = {hh_reg[k], 64'd0} + {31'd0, lh_reg[k], 33'd0} + {64'd0, ll_reg[k]};
        assign ys   = prod[125:62];

        always_ff @(posedge clk)
        begin
            y_reg[k+1] <= ys[63] ? (ys >> 1) : ys;
            f_reg[k+1] <= {fa_reg[k][FRAC_W-2:0], ys[63]};
            m_reg[k+1] <= ma_reg[k];
        end
    end

    // magnitude of log2: exponent plus or minus fraction
    logic [MAG_W-1:0] mag_reg;
    logic             neg_reg, neg2_reg, neg3_reg;
    kind_t            kind1_reg, kind2_reg, kind3_reg;
    logic             v1_reg, v2_reg, v3_reg;
    logic [7:0]       e_abs;

    assign e_abs = m_reg[NSQ].expo[8] ? 8'(-m_reg[NSQ].expo) : m_reg[NSQ].expo[7:0];

    always_ff @(posedge clk)
    begin
        if (m_reg[NSQ].expo[8])
            mag_reg <= {e_abs[6:0], 56'd0} - {7'd0, f_reg[NSQ]};
        else
            mag_reg <= {e_abs[6:0], 56'd0} + {7'd0, f_reg[NSQ]};
        neg_reg   <= m_reg[NSQ].expo[8];
        kind1_reg <= m_reg[NSQ].kind;
    end

    // scaling multiply: partial products, then sum
    logic [63:0] pll_reg, plh_reg, phl_reg, phh_reg;
    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        pll_reg   <= mag_reg[31:0] * K[31:0];
        plh_reg   <= {1'b0, mag_reg[62:32]} * K[63:32];
        phl_reg   <= {1'b0, mag_reg[62:32]} * K[31:0];
        phh_reg   <= mag_reg[31:0] * K[63:32];
        neg2_reg  <= neg_reg;
        kind2_reg <= kind1_reg;
        prod_reg  <= PROD_W'({64'd0, plh_reg, 64'd0}
                           + {32'd0, phl_reg, 32'd0}
                           + {32'd0, phh_reg, 32'd0}
                           + {64'd0, pll_reg});
    end

    // rounding, range checks and output register
    logic [16:0] fl;
    logic [17:0] rd;
    logic [15:0] res;
    assign fl = prod_reg[126:110];
    assign rd = ({1'b0, prod_reg[126:110]} + {17'd0, prod_reg[109]});

    always_comb
    begin
        if (kind3_reg == KIND_SILENCE)
            res = SILENCE;
        else if (kind3_reg == KIND_SAT)
            res = POS_SAT;
        else if (!neg3_reg)
            res = (fl >= {1'b0, POS_SAT}) ? POS_SAT : rd[15:0];
        else
            res = (fl >= {1'b0, NEG_LIMIT}) ? SILENCE : 16'(-rd[15:0]);
    end

    always_ff @(posedge clk)
    begin
        neg3_reg  <= neg2_reg;
        kind3_reg <= kind2_reg;
        cdb       <= $signed(res);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            v1_reg    <= v_reg[NSQ];
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            out_valid <= v3_reg;
        end
    end

endmodule

FILE: hdl/float_to_centi_db_quantizer.sv
// Top level of the float to centi-dB quantizer: two level lanes in parallel.
// Depends on fcdb_pkg and fcdb_level.
//
// Usage: present a word on din and raise start; it is taken at that edge
// because busy is never raised. Each word holds a power value and a peak
// amplitude as single-precision bit patterns. The result word appears on
// dout for exactly one cycle with dout_valid high. A new word may be started
// every cycle; the lanes are fully pipelined, the depth being set by 56
// squaring steps of the log2 unit (two register stages each), plus decode,
// magnitude, two multiply stages and the output register. Throughput is
// one word per cycle.
// Reset clears every valid bit, so no result appears until a word is
// started. The receiver cannot stall, so no buffering is held.
// The power value is reported as 10*log10, the peak as 20*log10, in 0.01 dB.
`timescale 1ns / 1ps

module float_to_centi_db_quantizer #(
    parameter int SILENCE_CODE = -32768
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  fcdb_pkg::in_word_t  din,
    output fcdb_pkg::out_word_t dout,
    output logic              dout_valid
);
    import fcdb_pkg::*;

    localparam logic [15:0] SIL = SILENCE_CODE[15:0];

    logic accept;
    logic peak_valid;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // power lane
    fcdb_level #(.SCALE(64'd1000), .SILENCE(SIL)) u_power (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .bits      (din.power_bits),
        .out_valid (dout_valid),
        .cdb       (dout.power_cdb)
    );

    // peak lane
    fcdb_level #(.SCALE(64'd2000), .SILENCE(SIL)) u_peak (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept & ~peak_valid | accept),
        .bits      (din.peak_bits),
        .out_valid (peak_valid),
        .cdb       (dout.peak_cdb)
    );

endmodule

FILE: tb/fcdb_checker.sv
// Checker for the float to centi-dB quantizer: predicts each result word from the
// words taken in and compares it with what comes out. Depends on fcdb_pkg.
`timescale 1ns / 1ps

module fcdb_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  fcdb_pkg::in_word_t  din,
    input  fcdb_pkg::out_word_t dout,
    input  logic                dout_valid,
    output int                  fail_count,
    output int                  waiting
);
    import fcdb_pkg::*;

    localparam logic signed [15:0] SILENCE = -16'sd32768;
    localparam logic signed [15:0] TOP_SAT = 16'sd32767;

    out_word_t   pending_levels[$];
    logic [63:0] k_power, k_peak;

    // fraction bits of log2(y), y in Q62 within [1,2), by repeated squaring
    function automatic logic [63:0] log2_bits(input logic [63:0] y_in, input int n);
        logic [63:0]  y;
        logic [63:0]  f;
        logic [127:0] sq;
        y = y_in;
        f = '0;
        for (int i = 0; i < n; i++)
        begin
            sq = {64'd0, y} * {64'd0, y};
            y  = sq[125:62];
            f  = f << 1;
            if (y[63])
            begin
                f[0] = 1'b1;
                y    = y >> 1;
            end
        end
        return f;
    endfunction

    // scale / log2(10) as a truncated Q54 quotient
    function automatic logic [63:0] db_scale(input logic [63:0] s);
        logic [127:0] lg, num, q;
        lg  = {64'd0, (64'd3 << 60) + log2_bits(64'd5 << 60, 60)};
        num = {s << 50, 64'd0};
        q   = num / lg;
        return q[63:0];
    endfunction

    // level of one single-precision pattern in hundredths of a dB
    function automatic logic signed [15:0] centi_db_of(input logic [31:0] bits,
                                                       input logic [63:0] k);
        logic [7:0]   ex;
        logic [22:0]  man;
        logic [63:0]  frac, mag, hi, fl, rd;
        logic [127:0] prod;
        int           e;
        logic         neg;
        ex  = bits[30:23];
        man = bits[22:0];
        if (bits[31] || ex == 8'd0)
            return SILENCE;
        if (ex == 8'hFF)
            return (man != 0) ? SILENCE : TOP_SAT;
        frac = log2_bits({40'd0, 1'b1, man} << 39, 56);
        e    = int'(ex) - 127;
        neg  = (e < 0);
        if (!neg)
            mag = (64'(e) << 56) + frac;
        else
            mag = (64'(-e) << 56) - frac;
        prod = {64'd0, mag} * {64'd0, k};
        hi   = prod[127:64];
        fl   = hi >> 46;
        rd   = (hi + (64'd1 << 45)) >> 46;
        if (!neg)
            return (fl >= 64'd32767) ? TOP_SAT : 16'(rd);
        if (fl >= 64'd12000)
            return SILENCE;
        return -16'(rd);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fail_count = fail_count + 1;
    endtask

    initial
    begin
        fail_count = 0;
        k_power    = db_scale(64'd1000);
        k_peak     = db_scale(64'd2000);
    end

    assign waiting = pending_levels.size();

    // take words in and check words out
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && start && !busy)
        begin
            want.power_cdb = centi_db_of(din.power_bits, k_power);
            want.peak_cdb  = centi_db_of(din.peak_bits, k_peak);
            pending_levels = {pending_levels, want};
        end
        if (rst_n && dout_valid)
        begin
            if (pending_levels.size() == 0)
                report_mismatch("result word with none expected");
            else
            begin
                want = pending_levels.pop_front();
                if (dout.power_cdb !== want.power_cdb)
                    report_mismatch($sformatf("power_cdb %0d, want %0d",
                                              dout.power_cdb, want.power_cdb));
                if (dout.peak_cdb !== want.peak_cdb)
                    report_mismatch($sformatf("peak_cdb %0d, want %0d",
                                              dout.peak_cdb, want.peak_cdb));
            end
        end
    end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the float to centi-dB quantizer: clock, reset, stimulus
// and verdict. Depends on fcdb_pkg, float_to_centi_db_quantizer, fcdb_checker.
`timescale 1ns / 1ps

module tb_top;
    import fcdb_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_word_t  din;
    out_word_t dout;
    logic      dout_valid;
    int        fail_count;
    int        waiting;

    float_to_centi_db_quantizer uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .din(din), .dout(dout), .dout_valid(dout_valid)
    );

    fcdb_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .din(din),
        .dout(dout), .dout_valid(dout_valid),
        .fail_count(fail_count), .waiting(waiting)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // guard against a hang
    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    // one word, start held high; accepted at the edge where busy is low
    task automatic send_word(input logic [31:0] pw, input logic [31:0] pk);
        start <= 1'b1;
        din   <= '{power_bits: pw, peak_bits: pk};
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    // random pattern biased towards the interesting bands
    function automatic logic [31:0] pick_float(input int lo_ex, input int hi_ex);
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0, 1:    ;                                   // any pattern
            2:       v[30:23] = 8'($urandom_range(0, 2) == 0 ? 0 : 255);
            default:
            begin
                v[31]    = ($urandom_range(0, 15) == 0);
                v[30:23] = 8'($urandom_range(lo_ex, hi_ex));
            end
        endcase
        return v;
    endfunction

    initial
    begin
        logic [31:0] corner[$];
        int          burst;
        rst_n = 1'b0;
        start = 1'b0;
        din   = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zeros, signs, subnormals, NaN, infinities, unity, largest and
        // smallest normals, and the -120 dB thresholds of both lanes
        corner = '{32'h0000_0000, 32'h8000_0000, 32'hBF80_0000, 32'h0000_0001,
                   32'h007F_FFFF, 32'h7FC0_0000, 32'h7F80_0001, 32'hFFC0_0000,
                   32'h7F80_0000, 32'hFF80_0000, 32'h3F80_0000, 32'h4120_0000,
                   32'h7F7F_FFFF, 32'h0080_0000, 32'h2B8C_BCCC, 32'h2B8C_BCCD,
                   32'h2B8C_BCCB, 32'h3586_37BD, 32'h3586_37BE, 32'h3586_37BC,
                   32'h3F7F_FFFF, 32'h3F80_0001, 32'h5A2A_0000, 32'h7E80_0000,
                   32'hFFFF_FFFF};
        foreach (corner[i])
            send_word(corner[i], corner[corner.size() - 1 - i]);
        start <= 1'b0;
        @(posedge clk);

        // random words in bursts with gaps
        for (int n = 0; n < 1600; )
        begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst; b++)
                send_word(pick_float(80, 200), pick_float(100, 175));
            n = n + burst;
            start <= 1'b0;
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 12)) @(posedge clk);
            else
                @(posedge clk);
        end

        // drain, then allow for the pipeline depth
        while (waiting != 0)
            @(posedge clk);
        repeat (130) @(posedge clk);
        if (fail_count == 0 && waiting == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/fcdb_pkg.sv
hdl/fcdb_level.sv
hdl/float_to_centi_db_quantizer.sv
tb/fcdb_checker.sv
tb/tb_top.sv
